// ----- rtl/lesf_pkg.sv -----
// Package for the largest empty square finder.
// Holds the configuration register indexes, fixed field widths, default sizes
// and the stage-one control struct. No dependencies.
package lesf_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;
	localparam int CHAR_W     = 8;
	localparam int SIZE_W     = 11;
	localparam int POS_W      = 10;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_HEIGHT = 1024;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_CHAR  = 2'd2;

	localparam logic [CFG_DATA_W-1:0] RST_GRID_WIDTH  = 11'd1;
	localparam logic [CFG_DATA_W-1:0] RST_GRID_HEIGHT = 11'd1;
	localparam logic [CHAR_W-1:0]     RST_EMPTY_CHAR  = 8'd46;

	typedef struct packed {
		logic valid;
		logic is_empty;
		logic row_end;
		logic grid_end;
	} lesf_ctl_t;

endpackage

// ----- rtl/largest_empty_square_finder.sv -----
// Top level of the largest empty square finder.
// Instantiates lesf_scan, lesf_line_buf and lesf_dp; depends on lesf_pkg.
//
//   Channel   Direction   Handshake            Payload
//   config    in          cfg_we               cfg_index, cfg_data
//   cell      in          in_valid / in_stall  cell_char
//   result    out         out_valid / out_stall square_size, square_col, square_row
//
// One cell is taken per cycle while in_stall is low; a cell's value is computed
// in stage one from the registered read of the line buffer.
// The result register loads when the grid's last cell fires from stage one.
// in_stall rises only when the last cell of a grid waits behind an untaken
// result. Reset clears counters and best square; the line buffer is not cleared.
module largest_empty_square_finder import lesf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [CHAR_W-1:0]     cell_char,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [SIZE_W-1:0]     square_size,
	output logic [POS_W-1:0]      square_col,
	output logic [POS_W-1:0]      square_row
);

	localparam int CW      = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int RW      = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int MIN_DIM = (MAX_WIDTH < MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
	localparam int VW      = $clog2(MIN_DIM + 1);

	lesf_ctl_t     ctl_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [CW-1:0] rd_col;
	logic [VW-1:0] rd_data;
	logic          acc;
	logic          fire_s1;
	logic          hold_s1;
	logic          wr_en;
	logic [CW-1:0] wr_addr;
	logic [VW-1:0] wr_data;

	assign in_stall = ctl_s1.valid && hold_s1;
	assign acc      = in_valid && !in_stall;

	lesf_scan #(
		.MAX_WIDTH (MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT),
		.CW        (CW),
		.RW        (RW)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.acc      (acc),
		.cell_char(cell_char),
		.fire_s1  (fire_s1),
		.rd_col   (rd_col),
		.ctl_s1   (ctl_s1),
		.col_s1   (col_s1),
		.row_s1   (row_s1)
	);

	lesf_line_buf #(
		.DEPTH(MAX_WIDTH),
		.AW   (CW),
		.DW   (VW)
	) u_line_buf (
		.clk    (clk),
		.rd_en  (acc),
		.rd_addr(rd_col),
		.rd_data(rd_data),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_data)
	);

	lesf_dp #(
		.CW(CW),
		.RW(RW),
		.VW(VW)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_s1     (ctl_s1),
		.col_s1     (col_s1),
		.row_s1     (row_s1),
		.rd_data    (rd_data),
		.acc        (acc),
		.rd_col     (rd_col),
		.fire_s1    (fire_s1),
		.hold_s1    (hold_s1),
		.wr_en      (wr_en),
		.wr_addr    (wr_addr),
		.wr_data    (wr_data),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.square_size(square_size),
		.square_col (square_col),
		.square_row (square_row)
	);

endmodule

// ----- rtl/lesf_line_buf.sv -----
// Line buffer holding the previous row's square sizes.
// One write port and one registered read port with read enable.
// Depends on nothing but its parameters.
module lesf_line_buf #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [DW-1:0] rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [DW-1:0] wr_data
);

	logic [DW-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ----- rtl/lesf_scan.sv -----
// Scan stage: configuration registers, column and row counters, and the
// stage-one pipeline register. Depends on lesf_pkg.
module lesf_scan import lesf_pkg::*; #(
	parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = DEF_MAX_HEIGHT,
	parameter int CW         = 10,
	parameter int RW         = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  acc,
	input  logic [CHAR_W-1:0]     cell_char,
	input  logic                  fire_s1,
	output logic [CW-1:0]         rd_col,
	output lesf_ctl_t             ctl_s1,
	output logic [CW-1:0]         col_s1,
	output logic [RW-1:0]         row_s1
);

	logic [CFG_DATA_W-1:0] grid_width_q;
	logic [CFG_DATA_W-1:0] grid_height_q;
	logic [CHAR_W-1:0]     empty_char_q;
	logic [CW-1:0]         col_q;
	logic [RW-1:0]         row_q;
	logic [CW-1:0]         last_col;
	logic [RW-1:0]         last_row;
	logic                  row_end;
	logic                  grid_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= RST_GRID_WIDTH;
			grid_height_q <= RST_GRID_HEIGHT;
			empty_char_q  <= RST_EMPTY_CHAR;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				CFG_EMPTY_CHAR:  empty_char_q  <= cfg_data[CHAR_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_width_q == '0) begin
			last_col = '0;
		end else if (32'(grid_width_q) > 32'(MAX_WIDTH)) begin
			last_col = CW'(MAX_WIDTH - 1);
		end else begin
			last_col = CW'(grid_width_q - 1'b1);
		end
		if (grid_height_q == '0) begin
			last_row = '0;
		end else if (32'(grid_height_q) > 32'(MAX_HEIGHT)) begin
			last_row = RW'(MAX_HEIGHT - 1);
		end else begin
			last_row = RW'(grid_height_q - 1'b1);
		end
	end

	assign row_end  = (col_q >= last_col);
	assign grid_end = row_end && (row_q >= last_row);
	assign rd_col   = col_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (grid_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (acc) begin
			ctl_s1.valid    <= 1'b1;
			ctl_s1.is_empty <= (cell_char == empty_char_q);
			ctl_s1.row_end  <= row_end;
			ctl_s1.grid_end <= grid_end;
		end else if (fire_s1) begin
			ctl_s1.valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			col_s1 <= col_q;
			row_s1 <= row_q;
		end
	end

endmodule

// ----- rtl/lesf_dp.sv -----
// Stage-one datapath: minimum-of-three rule, forwarding from the line buffer
// write, best-square tracking and the result register. Depends on lesf_pkg.
module lesf_dp import lesf_pkg::*; #(
	parameter int CW = 10,
	parameter int RW = 10,
	parameter int VW = 11
) (
	input  logic              clk,
	input  logic              arst_n,
	input  lesf_ctl_t         ctl_s1,
	input  logic [CW-1:0]     col_s1,
	input  logic [RW-1:0]     row_s1,
	input  logic [VW-1:0]     rd_data,
	input  logic              acc,
	input  logic [CW-1:0]     rd_col,
	output logic              fire_s1,
	output logic              hold_s1,
	output logic              wr_en,
	output logic [CW-1:0]     wr_addr,
	output logic [VW-1:0]     wr_data,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [SIZE_W-1:0] square_size,
	output logic [POS_W-1:0]  square_col,
	output logic [POS_W-1:0]  square_row
);

	localparam int MW = (VW > CW) ? VW : CW;
	localparam int SW = ((MW > RW) ? MW : RW) + 1;

	logic [VW-1:0] left_q;
	logic [VW-1:0] diag_q;
	logic [VW-1:0] best_size_q;
	logic [CW-1:0] best_col_q;
	logic [RW-1:0] best_row_q;
	logic          fwd_q;
	logic [VW-1:0] fwd_data_q;
	logic [VW-1:0] up;
	logic [VW-1:0] left;
	logic [VW-1:0] diag;
	logic [VW-1:0] m2;
	logic [VW-1:0] m3;
	logic [SW-1:0] cand;
	logic [SW-1:0] rlim;
	logic [SW-1:0] clim;
	logic [SW-1:0] vsum;
	logic [VW-1:0] v;
	logic          better;
	logic [CW-1:0] new_col;
	logic [RW-1:0] new_row;

	assign hold_s1 = ctl_s1.grid_end && out_valid && out_stall;
	assign fire_s1 = ctl_s1.valid && !hold_s1;

	always_comb begin
		up   = (row_s1 == '0) ? '0 : (fwd_q ? fwd_data_q : rd_data);
		left = (col_s1 == '0) ? '0 : left_q;
		diag = ((row_s1 == '0) || (col_s1 == '0)) ? '0 : diag_q;
		m2   = (up < left) ? up : left;
		m3   = (m2 < diag) ? m2 : diag;
		cand = SW'(m3) + 1'b1;
		rlim = SW'(row_s1) + 1'b1;
		clim = SW'(col_s1) + 1'b1;
		vsum = cand;
		if (vsum > rlim) begin
			vsum = rlim;
		end
		if (vsum > clim) begin
			vsum = clim;
		end
		v       = ctl_s1.is_empty ? VW'(vsum) : '0;
		better  = (v > best_size_q);
		new_col = CW'(clim - SW'(v));
		new_row = RW'(rlim - SW'(v));
	end

	assign wr_en   = fire_s1;
	assign wr_addr = col_s1;
	assign wr_data = v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
		end else if (acc) begin
			fwd_q <= fire_s1 && (col_s1 == rd_col);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			fwd_data_q <= v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q      <= '0;
			diag_q      <= '0;
			best_size_q <= '0;
			best_col_q  <= '0;
			best_row_q  <= '0;
		end else if (fire_s1) begin
			if (ctl_s1.row_end) begin
				left_q <= '0;
				diag_q <= '0;
			end else begin
				left_q <= v;
				diag_q <= up;
			end
			if (ctl_s1.grid_end) begin
				best_size_q <= '0;
				best_col_q  <= '0;
				best_row_q  <= '0;
			end else if (better) begin
				best_size_q <= v;
				best_col_q  <= new_col;
				best_row_q  <= new_row;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (fire_s1 && ctl_s1.grid_end) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1 && ctl_s1.grid_end) begin
			if (better) begin
				square_size <= SIZE_W'(v);
				square_col  <= POS_W'(new_col);
				square_row  <= POS_W'(new_row);
			end else begin
				square_size <= SIZE_W'(best_size_q);
				square_col  <= POS_W'(best_col_q);
				square_row  <= POS_W'(best_row_q);
			end
		end
	end

endmodule

// ----- rtl/lesf_checker.sv -----
// Port-level checker for the largest empty square finder, bound to the top.
// Depends on lesf_pkg.
module lesf_checker import lesf_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_stall,
	input logic              out_valid,
	input logic              out_stall,
	input logic [SIZE_W-1:0] square_size,
	input logic [POS_W-1:0]  square_col,
	input logic [POS_W-1:0]  square_row
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(square_size)
			&& $stable(square_col) && $stable(square_row))
		else $error("result changed while stalled");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a waiting result");

	a_stall_release: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall && in_valid |=> !out_stall || out_valid)
		else $error("input stalled with empty result register");

	a_empty_origin: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (square_size == '0) |-> (square_col == '0) && (square_row == '0))
		else $error("zero-size result with nonzero corner");

endmodule

bind largest_empty_square_finder lesf_checker u_lesf_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.square_size(square_size),
	.square_col (square_col),
	.square_row (square_row)
);
